// ----- src/pva_pkg.sv -----
// Package for the polygon vertex angle block.
// Holds payload types, stage structs, fixed widths and the CORDIC arctangent table.
// No dependencies.
package pva_pkg;

	localparam int COORD_BITS          = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 7;
	localparam int CORDIC_STAGES_DEF   = 16;

	localparam int EDGE_BITS     = 21;
	localparam int PROD_BITS     = 2 * EDGE_BITS;
	localparam int VEC_BITS      = 45;
	localparam int MAG_BITS      = 41;
	localparam int ACC_BITS      = 32;
	localparam int ANGLE_BITS    = 16;
	localparam int ATAN_IDX_BITS = 5;

	localparam logic [ACC_BITS-1:0] HALF_TURN = 32'h8000_0000;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] prev_x;
		logic signed [COORD_BITS-1:0] prev_y;
		logic signed [COORD_BITS-1:0] here_x;
		logic signed [COORD_BITS-1:0] here_y;
		logic signed [COORD_BITS-1:0] next_x;
		logic signed [COORD_BITS-1:0] next_y;
	} pva_in_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle_deg;
		logic                  degenerate;
	} pva_out_t;

	typedef struct packed {
		logic                       valid;
		logic                       degen;
		logic signed [VEC_BITS-1:0] x;
		logic signed [VEC_BITS-1:0] y;
	} pva_vec_t;

	typedef struct packed {
		logic                       valid;
		logic                       degen;
		logic signed [VEC_BITS-1:0] x;
		logic signed [VEC_BITS-1:0] y;
		logic [ACC_BITS-1:0]        acc;
	} pva_rot_t;

	typedef struct packed {
		logic                valid;
		logic                degen;
		logic [ACC_BITS-1:0] acc;
	} pva_ang_t;

	// arctan(2^-i) in binary angle units, one turn = 2^32
	function automatic logic [ACC_BITS-1:0] atan_turn(input logic [ATAN_IDX_BITS-1:0] idx);
		logic [ACC_BITS-1:0] r;
		case (idx)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2F9;
			5'd15:   r = 32'h0000517C;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A2F;
			5'd19:   r = 32'h00000517;
			5'd20:   r = 32'h0000028B;
			5'd21:   r = 32'h00000145;
			5'd22:   r = 32'h000000A2;
			5'd23:   r = 32'h00000051;
			5'd24:   r = 32'h00000028;
			5'd25:   r = 32'h00000014;
			5'd26:   r = 32'h0000000A;
			5'd27:   r = 32'h00000005;
			5'd28:   r = 32'h00000002;
			5'd29:   r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ----- src/pva_front.sv -----
// Front end: edge vectors, zero-length detect, range shrink, dot and cross products.
// Four register stages; depends on pva_pkg.
module pva_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  pva_pkg::pva_in_t  in_item,
	output pva_pkg::pva_vec_t vec
);

	localparam int CB  = pva_pkg::COORD_BITS;
	localparam int DW  = CB + 1;
	localparam int EB  = pva_pkg::EDGE_BITS;
	localparam int PB  = pva_pkg::PROD_BITS;
	localparam int VB  = pva_pkg::VEC_BITS;
	localparam int SW  = (DW > EB + 1) ? DW : EB + 1;
	localparam int SHW = $clog2(DW);

	localparam logic signed [SW-1:0] FIT_HI = SW'((1 << (EB - 1)) - 1);
	localparam logic signed [SW-1:0] FIT_LO = -FIT_HI;

	function automatic logic [SHW-1:0] shrink_amt(input logic signed [DW-1:0] a,
	                                              input logic signed [DW-1:0] b);
		logic signed [SW-1:0] ta;
		logic signed [SW-1:0] tb;
		logic [SHW-1:0]       amt;
		amt = '0;
		for (int s = DW - 1; s >= 0; s--) begin
			ta = SW'(a >>> s);
			tb = SW'(b >>> s);
			if (ta <= FIT_HI && ta >= FIT_LO && tb <= FIT_HI && tb >= FIT_LO)
				amt = SHW'(s);
		end
		return amt;
	endfunction

	logic                 valid_s1, degen_s1;
	logic signed [DW-1:0] ux_s1, uy_s1, vx_s1, vy_s1;
	logic                 valid_s2, degen_s2;
	logic signed [EB-1:0] ux_s2, uy_s2, vx_s2, vy_s2;
	logic                 valid_s3, degen_s3;
	logic signed [PB-1:0] pxx_s3, pyy_s3, pyx_s3, pxy_s3;
	logic                 valid_s4, degen_s4;
	logic signed [VB-1:0] x_s4, y_s4;

	logic signed [DW-1:0] ux, uy, vx, vy;
	logic [SHW-1:0]       sh_u, sh_v;
	logic signed [SW-1:0] ex_u, ey_u, ex_v, ey_v;

	assign ux = {in_item.prev_x[CB-1], in_item.prev_x} - {in_item.here_x[CB-1], in_item.here_x};
	assign uy = {in_item.prev_y[CB-1], in_item.prev_y} - {in_item.here_y[CB-1], in_item.here_y};
	assign vx = {in_item.next_x[CB-1], in_item.next_x} - {in_item.here_x[CB-1], in_item.here_x};
	assign vy = {in_item.next_y[CB-1], in_item.next_y} - {in_item.here_y[CB-1], in_item.here_y};

	always_comb begin
		sh_u = shrink_amt(ux_s1, uy_s1);
		sh_v = shrink_amt(vx_s1, vy_s1);
		ex_u = SW'(ux_s1) >>> sh_u;
		ey_u = SW'(uy_s1) >>> sh_u;
		ex_v = SW'(vx_s1) >>> sh_v;
		ey_v = SW'(vy_s1) >>> sh_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s1 <= (ux == '0 && uy == '0) || (vx == '0 && vy == '0);
			ux_s1    <= ux;
			uy_s1    <= uy;
			vx_s1    <= vx;
			vy_s1    <= vy;
			degen_s2 <= degen_s1;
			ux_s2    <= ex_u[EB-1:0];
			uy_s2    <= ey_u[EB-1:0];
			vx_s2    <= ex_v[EB-1:0];
			vy_s2    <= ey_v[EB-1:0];
			degen_s3 <= degen_s2;
			pxx_s3   <= ux_s2 * vx_s2;
			pyy_s3   <= uy_s2 * vy_s2;
			pyx_s3   <= uy_s2 * vx_s2;
			pxy_s3   <= ux_s2 * vy_s2;
			degen_s4 <= degen_s3;
			x_s4     <= VB'(pxx_s3) + VB'(pyy_s3);
			y_s4     <= VB'(pyx_s3) - VB'(pxy_s3);
		end
	end

	assign vec.valid = valid_s4;
	assign vec.degen = degen_s4;
	assign vec.x     = x_s4;
	assign vec.y     = y_s4;

endmodule

// ----- src/pva_norm.sv -----
// Normalizer: scales dot and cross up until the larger magnitude reaches 2^40,
// then folds the left half plane onto the right. Four register stages; depends on pva_pkg.
module pva_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  pva_pkg::pva_vec_t vec,
	output pva_pkg::pva_rot_t rot
);

	localparam int VB = pva_pkg::VEC_BITS;
	localparam int MB = pva_pkg::MAG_BITS;
	localparam int AB = pva_pkg::ACC_BITS;

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                 degen_s1, degen_s2, degen_s3, degen_s4;
	logic signed [VB-1:0] x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic [MB-1:0]        m_s1, m_s2;
	logic [AB-1:0]        acc_s4;

	logic [VB-1:0]        ax, ay;
	logic signed [VB-1:0] xa, ya, xb, yb;
	logic [MB-1:0]        ma, mb;

	assign ax = vec.x[VB-1] ? -vec.x : vec.x;
	assign ay = vec.y[VB-1] ? -vec.y : vec.y;

	// coarse shifts by 32, 16, 8
	always_comb begin
		xa = x_s1;
		ya = y_s1;
		ma = m_s1;
		for (int j = 5; j >= 3; j--) begin
			if ((ma >> (MB - (1 << j))) == '0) begin
				xa = xa <<< (1 << j);
				ya = ya <<< (1 << j);
				ma = ma << (1 << j);
			end
		end
	end

	// fine shifts by 4, 2, 1
	always_comb begin
		xb = x_s2;
		yb = y_s2;
		mb = m_s2;
		for (int j = 2; j >= 0; j--) begin
			if ((mb >> (MB - (1 << j))) == '0) begin
				xb = xb <<< (1 << j);
				yb = yb <<< (1 << j);
				mb = mb << (1 << j);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vec.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s1 <= vec.degen;
			x_s1     <= vec.x;
			y_s1     <= vec.y;
			m_s1     <= ax[MB-1:0] | ay[MB-1:0];
			degen_s2 <= degen_s1;
			x_s2     <= xa;
			y_s2     <= ya;
			m_s2     <= ma;
			degen_s3 <= degen_s2;
			x_s3     <= xb;
			y_s3     <= yb;
			degen_s4 <= degen_s3;
			if (x_s3 < 0) begin
				x_s4   <= -x_s3;
				y_s4   <= -y_s3;
				acc_s4 <= pva_pkg::HALF_TURN;
			end else begin
				x_s4   <= x_s3;
				y_s4   <= y_s3;
				acc_s4 <= '0;
			end
		end
	end

	assign rot.valid = valid_s4;
	assign rot.degen = degen_s4;
	assign rot.x     = x_s4;
	assign rot.y     = y_s4;
	assign rot.acc   = acc_s4;

endmodule

// ----- src/pva_cordic.sv -----
// Vectoring CORDIC: one register stage per micro-rotation, accumulating the angle.
// Depends on pva_pkg for the arctangent table and stage structs.
module pva_cordic #(
	parameter int STAGES = pva_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  pva_pkg::pva_rot_t rot,
	output pva_pkg::pva_ang_t ang
);

	localparam int VB = pva_pkg::VEC_BITS;
	localparam int AB = pva_pkg::ACC_BITS;
	localparam int IW = pva_pkg::ATAN_IDX_BITS;

	logic [STAGES-1:0]    valid_s;
	logic [STAGES-1:0]    degen_s;
	logic signed [VB-1:0] x_s   [STAGES];
	logic signed [VB-1:0] y_s   [STAGES];
	logic [AB-1:0]        acc_s [STAGES];

	logic                 src_degen [STAGES];
	logic signed [VB-1:0] src_x     [STAGES];
	logic signed [VB-1:0] src_y     [STAGES];
	logic [AB-1:0]        src_acc   [STAGES];

	always_comb begin
		src_degen[0] = rot.degen;
		src_x[0]     = rot.x;
		src_y[0]     = rot.y;
		src_acc[0]   = rot.acc;
		for (int i = 1; i < STAGES; i++) begin
			src_degen[i] = degen_s[i-1];
			src_x[i]     = x_s[i-1];
			src_y[i]     = y_s[i-1];
			src_acc[i]   = acc_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s <= '0;
		else if (en)
			valid_s <= {valid_s[STAGES-2:0], rot.valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < STAGES; i++) begin
				degen_s[i] <= src_degen[i];
				if (src_y[i] > 0) begin
					x_s[i]   <= src_x[i] + (src_y[i] >>> i);
					y_s[i]   <= src_y[i] - (src_x[i] >>> i);
					acc_s[i] <= src_acc[i] + pva_pkg::atan_turn(IW'(i));
				end else begin
					x_s[i]   <= src_x[i] - (src_y[i] >>> i);
					y_s[i]   <= src_y[i] + (src_x[i] >>> i);
					acc_s[i] <= src_acc[i] - pva_pkg::atan_turn(IW'(i));
				end
			end
		end
	end

	assign ang.valid = valid_s[STAGES-1];
	assign ang.degen = degen_s[STAGES-1];
	assign ang.acc   = acc_s[STAGES-1];

endmodule

// ----- src/pva_out.sv -----
// Output stage: binary angle to degrees with rounding, wrap of a full turn,
// output register with skid slot and the pipeline advance. Depends on pva_pkg.
module pva_out #(
	parameter int FRAC = pva_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pva_pkg::pva_ang_t ang,
	output logic              en,
	output logic              out_valid,
	input  logic              out_ready,
	output pva_pkg::pva_out_t out_item
);

	localparam int AB   = pva_pkg::ACC_BITS;
	localparam int OB   = pva_pkg::ANGLE_BITS;
	localparam int FW   = 9 + FRAC;
	localparam int PW   = AB + FW;
	localparam int SUMW = (PW + 1 > AB + OB) ? PW + 1 : AB + OB;
	localparam int RW   = SUMW - AB;

	localparam logic [FW-1:0] FULL = FW'(360 << FRAC);

	logic              valid_s1, degen_s1;
	logic [PW-1:0]     prod_s1;
	logic [SUMW-1:0]   sum;
	logic [RW-1:0]     res;
	pva_pkg::pva_out_t nxt;

	pva_pkg::pva_out_t out_q, skid_q;
	logic              out_valid_q, skid_valid_q;

	assign en = !skid_valid_q;

	always_comb begin
		sum = SUMW'(prod_s1) + SUMW'(pva_pkg::HALF_TURN);
		res = sum[SUMW-1:AB];
		nxt.degenerate = degen_s1;
		if (degen_s1 || res >= RW'(FULL))
			nxt.angle_deg = '0;
		else
			nxt.angle_deg = res[OB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= ang.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s1 <= ang.degen;
			prod_s1  <= PW'(ang.acc) * PW'(FULL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready)
				skid_valid_q <= 1'b0;
		end else if (valid_s1) begin
			if (out_valid_q && !out_ready)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready)
				out_q <= skid_q;
		end else if (valid_s1) begin
			if (out_valid_q && !out_ready)
				skid_q <= nxt;
			else
				out_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ----- src/polygon_vertex_angle.sv -----
// Top level of the polygon vertex angle block: front end, normalizer, CORDIC, output.
// Depends on pva_pkg, pva_front, pva_norm, pva_cordic and pva_out.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid / in_ready | in_item  (prev, here, next x/y)
//   output  | out_valid/out_ready | out_item (angle_deg, degenerate)
//
// One item per cycle sustained while the output does not stall; the path runs through the
// four front stages, four normalizer stages, one stage per CORDIC micro-rotation,
// the degree scaling multiply and the output register.
// Reset clears all valid bits; payload registers are not reset.
// A stall at the output parks one item in a skid slot; the pipe holds while it is full.
module polygon_vertex_angle #(
	parameter int ANGLE_FRAC_BITS = pva_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = pva_pkg::CORDIC_STAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pva_pkg::pva_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output pva_pkg::pva_out_t out_item
);

	logic              en;
	pva_pkg::pva_vec_t vec;
	pva_pkg::pva_rot_t rot;
	pva_pkg::pva_ang_t ang;

	assign in_ready = en;

	pva_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_item  (in_item),
		.vec      (vec)
	);

	pva_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vec    (vec),
		.rot    (rot)
	);

	pva_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.rot    (rot),
		.ang    (ang)
	);

	pva_out #(
		.FRAC (ANGLE_FRAC_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ang       (ang),
		.en        (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("pipe stalled with no item at the output");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !out_ready |=> !in_ready && out_valid)
		else $error("parked item dropped during output stall");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.degenerate |-> out_item.angle_deg == '0)
		else $error("degenerate item with nonzero angle");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for polygon_vertex_angle: directed and random vertex triples under random
// input gaps and output stalls, each result checked against an in-bench angle predictor.
// Depends on pva_pkg and polygon_vertex_angle.
module testbench;

	localparam int     DRAIN_CYCLES = pva_pkg::CORDIC_STAGES_DEF + 18;
	localparam int     IDLE_LIMIT   = 2000;
	localparam longint EDGE_LIMIT   = longint'(1) << 20;
	localparam longint VEC_FLOOR    = longint'(1) << 40;
	localparam longint FULL_ANGLE   = longint'(360) << pva_pkg::ANGLE_FRAC_BITS_DEF;

	typedef enum int {READY_STEADY, READY_CHOPPY, READY_SLOW} ready_mode_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	pva_pkg::pva_in_t  in_item   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	pva_pkg::pva_out_t out_item;

	pva_pkg::pva_out_t pending_angles[$];
	pva_pkg::pva_out_t want;
	int                mismatches  = 0;
	int                burst_left  = 0;
	int                idle_cycles = 0;
	int                ready_run   = 0;
	int                ready_phase = 0;
	ready_mode_t       ready_mode  = READY_STEADY;

	logic [31:0] atan_units [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	polygon_vertex_angle dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic pva_pkg::pva_out_t vertex_angle(pva_pkg::pva_in_t it);
		longint            ux, uy, vx, vy, cx, cy, dx, dy;
		logic [31:0]       acc;
		longint unsigned   scaled;
		pva_pkg::pva_out_t r;
		int                n, i;
		ux = longint'(it.prev_x) - longint'(it.here_x);
		uy = longint'(it.prev_y) - longint'(it.here_y);
		vx = longint'(it.next_x) - longint'(it.here_x);
		vy = longint'(it.next_y) - longint'(it.here_y);
		r = '0;
		if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0)) begin
			r.degenerate = 1'b1;
			return r;
		end
		while (mag(ux) >= EDGE_LIMIT || mag(uy) >= EDGE_LIMIT) begin
			ux = ux >>> 1;
			uy = uy >>> 1;
		end
		while (mag(vx) >= EDGE_LIMIT || mag(vy) >= EDGE_LIMIT) begin
			vx = vx >>> 1;
			vy = vy >>> 1;
		end
		cx = ux * vx + uy * vy;
		cy = uy * vx - ux * vy;
		while (mag(cx) < VEC_FLOOR && mag(cy) < VEC_FLOOR) begin
			cx = cx * 2;
			cy = cy * 2;
		end
		acc = '0;
		if (cx < 0) begin
			cx = -cx;
			cy = -cy;
			acc = pva_pkg::HALF_TURN;
		end
		n = (pva_pkg::CORDIC_STAGES_DEF < 32) ? pva_pkg::CORDIC_STAGES_DEF : 32;
		for (i = 0; i < n; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy > 0) begin
				cx = cx + dx;
				cy = cy - dy;
				acc = acc + atan_units[i];
			end else begin
				cx = cx - dx;
				cy = cy + dy;
				acc = acc - atan_units[i];
			end
		end
		scaled = ((64'(acc) * 64'd360) << pva_pkg::ANGLE_FRAC_BITS_DEF) + 64'h8000_0000;
		scaled = scaled >> 32;
		if (scaled >= FULL_ANGLE)
			scaled = 0;
		r.angle_deg = scaled[15:0];
		return r;
	endfunction

	function automatic pva_pkg::pva_in_t make_item(int px, int py, int hx, int hy,
	                                               int nx, int ny);
		pva_pkg::pva_in_t it;
		it.prev_x = 16'(px);
		it.prev_y = 16'(py);
		it.here_x = 16'(hx);
		it.here_y = 16'(hy);
		it.next_x = 16'(nx);
		it.next_y = 16'(ny);
		return it;
	endfunction

	function automatic int rand_offset();
		int span;
		case ($urandom_range(0, 3))
			0:       span = 4;
			1:       span = 255;
			2:       span = 4000;
			default: span = 32767;
		endcase
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic report_mismatch(string what);
		$display("ERROR at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic send_item(pva_pkg::pva_in_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		pending_angles.push_back(vertex_angle(it));
	endtask

	task automatic test_zero_edges();
		send_item(make_item(100, -200, 100, -200, 50, 7));
		send_item(make_item(-3, 9, 12, 12, 12, 12));
		send_item(make_item(5, 5, 5, 5, 5, 5));
		send_item(make_item(-32768, -32768, -32768, -32768, 32767, 32767));
	endtask

	task automatic test_coordinate_extremes();
		send_item(make_item(-32768, -32768, 32767, 32767, 32767, -32768));
		send_item(make_item(32767, -32768, -32768, 32767, -32768, -32768));
		send_item(make_item(32767, 32767, -32768, -32768, -32768, 32767));
		send_item(make_item(-32768, 32767, 32767, -32768, 32767, 32767));
		send_item(make_item(32767, 32767, 0, 0, -32768, -32768));
		send_item(make_item(-1, -1, 0, 0, 1, -1));
	endtask

	task automatic test_principal_angles();
		send_item(make_item(10, 0, 0, 0, 5, 0));
		send_item(make_item(0, 10, 0, 0, 10, 0));
		send_item(make_item(-10, 0, 0, 0, 5, 0));
		send_item(make_item(0, -10, 0, 0, 10, 0));
		send_item(make_item(-10, 10, 0, 0, 10, 0));
		send_item(make_item(-10, -10, 0, 0, 10, 0));
		send_item(make_item(10, 10, 0, 0, 10, 0));
		send_item(make_item(10, -10, 0, 0, 10, 0));
	endtask

	task automatic test_full_turn_wrap();
		send_item(make_item(32767, -1, 0, 0, 32767, 0));
		send_item(make_item(32767, 1, 0, 0, 32767, 0));
		send_item(make_item(-32768, 0, 0, 0, -32767, 1));
	endtask

	task automatic test_random_polygons(int count);
		int hx, hy, px, py, nx, ny;
		repeat (count) begin
			hx = int'($urandom_range(0, 65535)) - 32768;
			hy = int'($urandom_range(0, 65535)) - 32768;
			px = hx + rand_offset();
			py = hy + rand_offset();
			nx = hx + rand_offset();
			ny = hy + rand_offset();
			case ($urandom_range(0, 39))
				0:       begin px = hx; py = hy; end
				1:       begin nx = hx; ny = hy; end
				default: ;
			endcase
			send_item(make_item(px, py, hx, hy, nx, ny));
		end
	endtask

	task automatic test_random_full_range(int count);
		pva_pkg::pva_in_t it;
		repeat (count) begin
			it = pva_pkg::pva_in_t'({$urandom(), $urandom(), $urandom()});
			send_item(it);
		end
	endtask

	task automatic test_near_collinear(int count);
		int hx, hy, vx, vy, k, sgn;
		repeat (count) begin
			hx  = int'($urandom_range(0, 2000)) - 1000;
			hy  = int'($urandom_range(0, 2000)) - 1000;
			vx  = int'($urandom_range(0, 4000)) - 2000;
			vy  = int'($urandom_range(0, 4000)) - 2000;
			k   = $urandom_range(1, 15);
			sgn = $urandom_range(0, 1) ? 1 : -1;
			send_item(make_item(hx + sgn * k * vx + int'($urandom_range(0, 4)) - 2,
				hy + sgn * k * vy + int'($urandom_range(0, 4)) - 2, hx, hy, hx + vx, hy + vy));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (ready_run > 0)
			ready_run--;
		else begin
			if (ready_phase == 0) begin
				ready_mode  = ready_mode_t'($urandom_range(0, 2));
				ready_phase = $urandom_range(20, 120);
			end
			ready_phase--;
			case (ready_mode)
				READY_STEADY: begin
					out_ready <= 1'b1;
					ready_run = $urandom_range(10, 40);
				end
				READY_CHOPPY: begin
					out_ready <= ($urandom_range(0, 3) != 0);
					ready_run = $urandom_range(0, 2);
				end
				default: begin
					out_ready <= 1'($urandom_range(0, 1));
					ready_run = $urandom_range(0, 20);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_angles.size() == 0)
				report_mismatch("result with no item outstanding");
			else begin
				want = pending_angles.pop_front();
				if (out_item.angle_deg !== want.angle_deg)
					report_mismatch($sformatf("angle_deg %0d, want %0d",
						out_item.angle_deg, want.angle_deg));
				if (out_item.degenerate !== want.degenerate)
					report_mismatch($sformatf("degenerate %b, want %b",
						out_item.degenerate, want.degenerate));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("TIMEOUT: no item moved for %0d cycles", IDLE_LIMIT);
				$display("polygon_vertex_angle verification failed");
				$finish;
			end else
				idle_cycles++;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_edges();
		test_coordinate_extremes();
		test_principal_angles();
		test_full_turn_wrap();
		test_random_polygons(450);
		test_random_full_range(150);
		test_near_collinear(100);
		in_valid <= 1'b0;
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("polygon_vertex_angle verification clean");
		else
			$display("polygon_vertex_angle verification failed");
		$finish;
	end

endmodule
